// File: rtl/tensor_permute_address_generator_assert.svh
// Assertion macros used by the tensor permute address generator checker
`ifndef TENSOR_PERMUTE_ADDRESS_GENERATOR_ASSERT_SVH
`define TENSOR_PERMUTE_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define TPAG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TPAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication: |=> followed by ##1
`define TPAG_ASSERT_LATER(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error(msg);

`endif

// File: rtl/tpag_pkg.sv
// Shared types, constants and register codes of the tensor permute address generator
package tpag_pkg;

   // Fixed field layout
   localparam int NUM_AXES    = 4;
   localparam int AXIS_W      = 2;
   localparam int RANK_W      = 3;
   localparam int DIM_FIELD_W = 13;
   localparam int MAP_W       = 8;
   localparam int ELEM_W      = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Parameter defaults
   localparam int DEF_MAX_RANK  = 4;
   localparam int DEF_ADDR_BITS = 20;
   localparam int DEF_DIM_BITS  = 12;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RANK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM1  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM3  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER = 3'd5;

   // Register reset values
   localparam logic [RANK_W-1:0]      RESET_RANK  = 3'd1;
   localparam logic [DIM_FIELD_W-1:0] RESET_DIM   = 13'd1;
   localparam logic [MAP_W-1:0]       RESET_ORDER = 8'd228;

   // Decoded configuration
   typedef struct packed {
      logic [RANK_W-1:0]                rank;
      logic [NUM_AXES-1:0][AXIS_W-1:0] src;
      logic                             static_err;
   } cfg_type;

   // Weight sequencer to coordinate counter: contribution load
   typedef struct packed {
      logic              en;
      logic [AXIS_W-1:0] axis;
   } load_ctl_type;

   // Weight sequencer status
   typedef struct packed {
      logic busy;
      logic too_big;
   } seq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STRIDE,
      ST_TOTAL,
      ST_LOAD
   } seq_state_type;

endpackage

// File: rtl/tensor_permute_address_generator.sv
// Top level of the tensor permute address generator
//
// Requests carry the elements of a column-major tensor (up to four axes) in
// source order, axis 0 fastest. Each response returns the element unchanged
// with its linear address in the permuted tensor, a last-element flag on the
// final element (the counter then wraps to the origin) and a config error
// flag. Registers are written through the csr_ channel, one index per cycle,
// with csr_ready always high; writes belong to idle periods.
// An accepted request passes through the input register and then the output
// register to rsp_. Throughput is one request per cycle while the weight
// sequencer is idle and no response is stalled: the address is the sum of
// four per-axis contributions that the counter keeps up to date with one add
// per step. After reset and after every register write the weight sequencer
// runs its stride, size and reload passes through one shared multiplier with
// req_ready low. A stalled response is held in the output register while
// one more request is taken into the input register; req_ready then drops.
module tensor_permute_address_generator
   import tpag_pkg::*;
#(
   parameter int MAX_RANK  = DEF_MAX_RANK,
   parameter int ADDR_BITS = DEF_ADDR_BITS,
   parameter int DIM_BITS  = DEF_DIM_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ELEM_W-1:0]      req_element_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_BITS-1:0]   rsp_dest_address,
   output logic [ELEM_W-1:0]      rsp_element_out,
   output logic                   rsp_last_element,
   output logic                   rsp_config_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type              cfg;
   logic [DIM_BITS:0]    ext    [NUM_AXES];
   logic [DIM_BITS-1:0]  coord  [NUM_AXES];
   logic [ADDR_BITS-1:0] weight [NUM_AXES];
   load_ctl_type         load_ctl;
   logic [ADDR_BITS-1:0] load_value;
   seq_status_type       status;
   logic [ADDR_BITS-1:0] dest_address;
   logic                 last_element;

   logic                 csr_fire;
   logic                 req_fire;
   logic                 out_free;
   logic                 move;

   logic                 in_valid_ff, in_valid_in;
   logic [ELEM_W-1:0]    in_elem_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [ADDR_BITS-1:0] out_addr_ff;
   logic [ELEM_W-1:0]    out_elem_ff;
   logic                 out_last_ff;
   logic                 out_err_ff;

   // Handshakes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign move      = in_valid_ff && out_free && !status.busy;
   assign req_ready = !status.busy && (!in_valid_ff || out_free);
   assign req_fire  = req_valid && req_ready;

   tpag_csr #(
      .MAX_RANK (MAX_RANK),
      .DIM_BITS (DIM_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_fire),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg),
      .ext      (ext)
   );

   tpag_weights #(
      .ADDR_BITS (ADDR_BITS),
      .DIM_BITS  (DIM_BITS)
   ) u_weights (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_fire),
      .cfg        (cfg),
      .ext        (ext),
      .coord      (coord),
      .weight     (weight),
      .load_ctl   (load_ctl),
      .load_value (load_value),
      .status     (status)
   );

   tpag_counter #(
      .ADDR_BITS (ADDR_BITS),
      .DIM_BITS  (DIM_BITS)
   ) u_counter (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .ext          (ext),
      .weight       (weight),
      .load_ctl     (load_ctl),
      .load_value   (load_value),
      .advance      (move),
      .coord        (coord),
      .dest_address (dest_address),
      .last_element (last_element)
   );

   // Valid bits of the input and output registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request, then the response
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_elem_ff <= req_element_bits;
      end
      if (move) begin
         out_addr_ff <= dest_address;
         out_elem_ff <= in_elem_ff;
         out_last_ff <= last_element;
         out_err_ff  <= cfg.static_err || status.too_big;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_dest_address = out_addr_ff;
   assign rsp_element_out  = out_elem_ff;
   assign rsp_last_element = out_last_ff;
   assign rsp_config_error = out_err_ff;

endmodule

// File: rtl/tpag_csr.sv
// Configuration registers and their decode into effective rank, extents and error
module tpag_csr
   import tpag_pkg::*;
#(
   parameter int MAX_RANK = DEF_MAX_RANK,
   parameter int DIM_BITS = DEF_DIM_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg,
   output logic [DIM_BITS:0]      ext [NUM_AXES]
);

   localparam int          EXT_W    = DIM_BITS + 1;
   localparam int          RANK_CAP = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
   localparam int unsigned DIM_LIM  = 32'd1 << DIM_BITS;

   logic [RANK_W-1:0]      rank_ff;
   logic [DIM_FIELD_W-1:0] dim_ff [NUM_AXES];
   logic [MAP_W-1:0]       map_ff;

   // Store register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RESET_RANK;
         map_ff  <= RESET_ORDER;
         for (int a = 0; a < NUM_AXES; a++) begin
            dim_ff[a] <= RESET_DIM;
         end
      end else if (wr_en) begin
         unique case (wr_index)
            REG_RANK:  rank_ff   <= wr_data[RANK_W-1:0];
            REG_DIM0:  dim_ff[0] <= wr_data[DIM_FIELD_W-1:0];
            REG_DIM1:  dim_ff[1] <= wr_data[DIM_FIELD_W-1:0];
            REG_DIM2:  dim_ff[2] <= wr_data[DIM_FIELD_W-1:0];
            REG_DIM3:  dim_ff[3] <= wr_data[DIM_FIELD_W-1:0];
            REG_ORDER: map_ff    <= wr_data[MAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp rank and extents, check the map, collect errors
   always_comb begin
      logic [RANK_W-1:0]   rank_eff;
      logic [NUM_AXES-1:0] seen;
      logic                err;
      int unsigned         dimv;
      int unsigned         extv;

      err      = 1'b0;
      rank_eff = rank_ff;
      seen     = '0;
      if (rank_ff == '0) begin
         err      = 1'b1;
         rank_eff = RANK_W'(1);
      end
      if (rank_ff > RANK_W'(RANK_CAP)) begin
         err      = 1'b1;
         rank_eff = RANK_W'(RANK_CAP);
      end

      for (int a = 0; a < NUM_AXES; a++) begin
         cfg.src[a] = map_ff[AXIS_W*a +: AXIS_W];
      end

      for (int a = 0; a < NUM_AXES; a++) begin
         dimv = 32'(dim_ff[a]);
         extv = 32'd1;
         if (RANK_W'(a) < rank_eff) begin
            if (dimv == 32'd0) begin
               err = 1'b1;
            end else if (dimv > DIM_LIM) begin
               err  = 1'b1;
               extv = DIM_LIM;
            end else begin
               extv = dimv;
            end
         end
         ext[a] = EXT_W'(extv);
      end

      // Each used destination axis must name a distinct used source axis
      for (int i = 0; i < NUM_AXES; i++) begin
         if (RANK_W'(i) < rank_eff) begin
            if (RANK_W'(cfg.src[i]) >= rank_eff || seen[cfg.src[i]]) begin
               err = 1'b1;
            end
            seen[cfg.src[i]] = 1'b1;
         end
      end

      cfg.rank       = rank_eff;
      cfg.static_err = err;
   end

endmodule

// File: rtl/tpag_weights.sv
// Sequencer that derives per-axis address weights and reloads contributions
module tpag_weights
   import tpag_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS,
   parameter int DIM_BITS  = DEF_DIM_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  cfg_type              cfg,
   input  logic [DIM_BITS:0]    ext [NUM_AXES],
   input  logic [DIM_BITS-1:0]  coord [NUM_AXES],
   output logic [ADDR_BITS-1:0] weight [NUM_AXES],
   output load_ctl_type         load_ctl,
   output logic [ADDR_BITS-1:0] load_value,
   output seq_status_type       status
);

   localparam int EXT_W  = DIM_BITS + 1;
   localparam int TOT_W  = ADDR_BITS + 1;
   localparam int PROD_W = TOT_W + EXT_W;
   localparam logic [PROD_W-1:0] ADDR_SPAN = {{(PROD_W-1){1'b0}}, 1'b1} << ADDR_BITS;

   seq_state_type        state_ff, state_in;
   logic [AXIS_W-1:0]    step_ff, step_in;
   logic [ADDR_BITS-1:0] stride_ff, stride_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic                 big_ff, big_in;
   logic [ADDR_BITS-1:0] weight_ff [NUM_AXES];
   logic [ADDR_BITS-1:0] weight_in [NUM_AXES];

   logic [AXIS_W-1:0] src;
   logic [AXIS_W-1:0] ext_sel;
   logic              step_used;
   logic              src_used;
   logic              last_step;
   logic [TOT_W-1:0]  op_a;
   logic [EXT_W-1:0]  op_b;
   logic [PROD_W-1:0] product;

   assign src       = cfg.src[step_ff];
   assign step_used = RANK_W'(step_ff) < cfg.rank;
   assign src_used  = RANK_W'(src) < cfg.rank;
   assign last_step = step_ff == AXIS_W'(NUM_AXES - 1);

   // Next state: stride pass, total pass, load pass, then idle
   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in = ST_STRIDE;
      end else begin
         unique case (state_ff)
            ST_STRIDE: if (last_step) state_in = ST_TOTAL;
            ST_TOTAL:  if (last_step) state_in = ST_LOAD;
            ST_LOAD:   if (last_step) state_in = ST_IDLE;
            ST_IDLE:   state_in = ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   // Outputs: operand selection for the shared multiplier, load strobe
   always_comb begin
      op_a     = '0;
      ext_sel  = step_ff;
      load_ctl = '0;
      unique case (state_ff)
         ST_STRIDE: begin
            op_a    = TOT_W'(stride_ff);
            ext_sel = src;
         end
         ST_TOTAL: begin
            op_a = total_ff;
         end
         ST_LOAD: begin
            op_a          = TOT_W'(weight_ff[step_ff]);
            load_ctl.en   = 1'b1;
            load_ctl.axis = step_ff;
         end
         ST_IDLE: ;
         default: ;
      endcase
      if (state_ff == ST_LOAD) begin
         op_b = EXT_W'(coord[step_ff]);
      end else begin
         op_b = ext[ext_sel];
      end
      status.busy    = state_ff != ST_IDLE;
      status.too_big = big_ff;
   end

   assign product    = PROD_W'(op_a) * PROD_W'(op_b);
   assign load_value = product[ADDR_BITS-1:0];

   // Next values of the step, stride, total, overflow and weight registers
   always_comb begin
      step_in   = step_ff;
      stride_in = stride_ff;
      total_in  = total_ff;
      big_in    = big_ff;
      weight_in = weight_ff;
      if (restart) begin
         step_in   = '0;
         stride_in = ADDR_BITS'(1);
         total_in  = TOT_W'(1);
         big_in    = 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            weight_in[a] = '0;
         end
      end else if (state_ff != ST_IDLE) begin
         step_in = step_ff + AXIS_W'(1);
         if (state_ff == ST_STRIDE && step_used) begin
            stride_in = product[ADDR_BITS-1:0];
            for (int a = 0; a < NUM_AXES; a++) begin
               if (src_used && src == AXIS_W'(a)) begin
                  weight_in[a] = weight_ff[a] + stride_ff;
               end
            end
         end
         if (state_ff == ST_TOTAL && step_used) begin
            total_in = product[TOT_W-1:0];
            if (product > ADDR_SPAN) begin
               big_in = 1'b1;
            end
         end
      end
   end

   // Registers; reset starts a derivation pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_STRIDE;
         step_ff   <= '0;
         stride_ff <= ADDR_BITS'(1);
         total_ff  <= TOT_W'(1);
         big_ff    <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            weight_ff[a] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         stride_ff <= stride_in;
         total_ff  <= total_in;
         big_ff    <= big_in;
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

// File: rtl/tpag_counter.sv
// Mixed-radix source coordinate counter with per-axis address contributions
module tpag_counter
   import tpag_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS,
   parameter int DIM_BITS  = DEF_DIM_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic [DIM_BITS:0]    ext [NUM_AXES],
   input  logic [ADDR_BITS-1:0] weight [NUM_AXES],
   input  load_ctl_type         load_ctl,
   input  logic [ADDR_BITS-1:0] load_value,
   input  logic                 advance,
   output logic [DIM_BITS-1:0]  coord [NUM_AXES],
   output logic [ADDR_BITS-1:0] dest_address,
   output logic                 last_element
);

   localparam int EXT_W = DIM_BITS + 1;

   logic [DIM_BITS-1:0]  coord_ff   [NUM_AXES];
   logic [DIM_BITS-1:0]  coord_in   [NUM_AXES];
   logic [ADDR_BITS-1:0] contrib_ff [NUM_AXES];
   logic [ADDR_BITS-1:0] contrib_in [NUM_AXES];

   // Sum contributions, detect the end, step the counter with carry
   always_comb begin
      logic                 carry;
      logic                 last;
      logic                 used;
      logic                 at_end;
      logic [ADDR_BITS-1:0] sum;

      carry = 1'b1;
      last  = 1'b1;
      sum   = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         sum    = sum + contrib_ff[a];
         used   = RANK_W'(a) < cfg.rank;
         at_end = ({1'b0, coord_ff[a]} + EXT_W'(1)) >= ext[a];
         coord_in[a]   = coord_ff[a];
         contrib_in[a] = contrib_ff[a];
         if (used && !at_end) begin
            last = 1'b0;
         end
         if (!used) begin
            coord_in[a]   = '0;
            contrib_in[a] = '0;
         end else if (carry) begin
            if (at_end) begin
               coord_in[a]   = '0;
               contrib_in[a] = '0;
            end else begin
               coord_in[a]   = coord_ff[a] + DIM_BITS'(1);
               contrib_in[a] = contrib_ff[a] + weight[a];
               carry         = 1'b0;
            end
         end
      end
      dest_address = sum;
      last_element = last;
   end

   // Advance on each request, reload a contribution after a config change
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            coord_ff[a]   <= '0;
            contrib_ff[a] <= '0;
         end
      end else if (load_ctl.en) begin
         contrib_ff[load_ctl.axis] <= load_value;
      end else if (advance) begin
         coord_ff   <= coord_in;
         contrib_ff <= contrib_in;
      end
   end

   assign coord = coord_ff;

endmodule

// File: rtl/tpag_checker.sv
// Port-level checker for the tensor permute address generator and its bind
`include "tensor_permute_address_generator_assert.svh"

module tpag_checker
   import tpag_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ADDR_BITS-1:0]   rsp_dest_address,
   input logic [ELEM_W-1:0]      rsp_element_out,
   input logic                   rsp_last_element,
   input logic                   rsp_config_error,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // A register write restarts weight derivation, so requests stall next cycle
   `TPAG_ASSERT_NEXT(a_csr_stalls_req, clock, reset, csr_valid && csr_ready, !req_ready, "request taken right after a register write")

   // An accepted request passes the input register and reaches the response register
   `TPAG_ASSERT_LATER(a_req_reaches_rsp, clock, reset, req_valid && req_ready && !(csr_valid && csr_ready), rsp_valid, "accepted request did not reach the response")

   // Leaving reset: nothing to deliver and weights not ready yet
   `TPAG_ASSERT_IMPL(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid && !req_ready, "activity right after reset")

   // A stalled response holds
   `TPAG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_dest_address) && $stable(rsp_element_out) && $stable(rsp_last_element) && $stable(rsp_config_error), "stalled response changed")

endmodule

bind tensor_permute_address_generator tpag_checker #(
   .ADDR_BITS (ADDR_BITS)
) u_tpag_checker (.*);
